// ----- hdl/cd_pkg.sv -----
package cd_pkg;

	localparam int ACC_SQ_W  = 27;
	localparam int ACC_DOT_W = 28;
	localparam int DIST_W    = 18;
	localparam int MUL_A_W   = 54;
	localparam int MUL_B_W   = 35;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int DSQ_W     = 55;
	localparam int KSQ_W     = 35;
	localparam int K_W       = 19;

	localparam logic [ACC_SQ_W-1:0]  SQ_MAX  = {ACC_SQ_W{1'b1}};
	localparam logic [DIST_W-1:0]    TWO_FIX = 18'd131072;
	localparam logic [K_W-1:0]       K_TOP   = 19'd131073;
	localparam int                   LHS_SHIFT = 34;

	typedef struct packed {
		logic [7:0] a_elem;
		logic [7:0] b_elem;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              zero_norm;
	} out_item_t;

	typedef enum logic [1:0] {
		MUL_P,
		MUL_D,
		MUL_K,
		MUL_R
	} mul_sel_t;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_P_GO   = 11'b00000000010,
		ST_P_WAIT = 11'b00000000100,
		ST_D_GO   = 11'b00000001000,
		ST_D_WAIT = 11'b00000010000,
		ST_K_GO   = 11'b00000100000,
		ST_K_WAIT = 11'b00001000000,
		ST_R_GO   = 11'b00010000000,
		ST_R_WAIT = 11'b00100000000,
		ST_DECIDE = 11'b01000000000,
		ST_OUT    = 11'b10000000000
	} state_t;

	typedef struct packed {
		logic     acc;
		logic     mul_start;
		mul_sel_t sel;
		logic     store_p;
		logic     store_d;
		logic     store_k;
		logic     decide;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic zero_norm;
		logic search_done;
		logic out_free;
	} sts_t;

	localparam logic [1:0] REG_ELEMENT_SIGNED = 2'd0;

endpackage

// ----- hdl/cd_mult.sv -----
module cd_mult (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cd_pkg::MUL_A_W-1:0] a,
	input  logic [cd_pkg::MUL_B_W-1:0] b,
	output logic                      done,
	output logic [cd_pkg::MUL_P_W-1:0] product
);
	import cd_pkg::*;

	logic               busy_q;
	logic [MUL_P_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [MUL_P_W-1:0] prod_q;

	// finished once no set multiplier bit remains
	assign done    = busy_q && (b_q == '0);
	assign product = prod_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// shift-add, one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= {{MUL_B_W{1'b0}}, a};
			b_q    <= b;
			prod_q <= '0;
		end else if (busy_q && !done) begin
			if (b_q[0]) begin
				prod_q <= prod_q + a_q;
			end
			a_q <= {a_q[MUL_P_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[MUL_B_W-1:1]};
		end
	end

endmodule

// ----- hdl/cd_dp.sv -----
module cd_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              element_signed,
	input  cd_pkg::in_item_t  in_data,
	input  cd_pkg::cmd_t      cmd,
	output cd_pkg::sts_t      sts,
	output logic              out_valid,
	input  logic              out_stall,
	output cd_pkg::out_item_t out_data
);
	import cd_pkg::*;

	logic signed [8:0]           ea, eb;
	logic signed [17:0]          sq_a, sq_b, prod_ab;
	logic [ACC_SQ_W:0]           sa_sum, sb_sum;
	logic [ACC_SQ_W-1:0]         sa_next, sb_next;
	logic signed [ACC_DOT_W:0]   dot_sum;
	logic signed [ACC_DOT_W-1:0] dot_next;

	logic [ACC_SQ_W-1:0]         sa_q, sb_q;
	logic signed [ACC_DOT_W-1:0] dot_q;

	logic [ACC_SQ_W-1:0]         sa_w_q, sb_w_q;
	logic signed [ACC_DOT_W-1:0] dot_w_q;
	logic                        zero_w_q;

	logic [MUL_A_W-1:0]          p_q;
	logic [DSQ_W-1:0]            dsq_q;
	logic [KSQ_W-1:0]            ksq_q;
	logic                        kneg_q;

	logic [DIST_W-1:0]           lo_q, hi_q;
	logic                        first_q;
	logic [DIST_W-1:0]           mid;
	logic signed [K_W-1:0]       k_val;
	logic [K_W-1:0]              k_abs;

	logic [ACC_DOT_W-1:0]        dot_abs;
	logic [MUL_A_W-1:0]          mul_a;
	logic [MUL_B_W-1:0]          mul_b;
	logic                        mul_done;
	logic [MUL_P_W-1:0]          mul_prod;
	logic [MUL_P_W-1:0]          lhs;
	logic                        test;

	logic                        out_valid_q;
	out_item_t                   out_q;

	// element products and saturating sums
	always_comb begin
		ea      = element_signed ? $signed({in_data.a_elem[7], in_data.a_elem})
		                         : $signed({1'b0, in_data.a_elem});
		eb      = element_signed ? $signed({in_data.b_elem[7], in_data.b_elem})
		                         : $signed({1'b0, in_data.b_elem});
		sq_a    = ea * ea;
		sq_b    = eb * eb;
		prod_ab = ea * eb;
		sa_sum  = {1'b0, sa_q} + {{(ACC_SQ_W + 1 - 17){1'b0}}, sq_a[16:0]};
		sb_sum  = {1'b0, sb_q} + {{(ACC_SQ_W + 1 - 17){1'b0}}, sq_b[16:0]};
		sa_next = sa_sum[ACC_SQ_W] ? SQ_MAX : sa_sum[ACC_SQ_W-1:0];
		sb_next = sb_sum[ACC_SQ_W] ? SQ_MAX : sb_sum[ACC_SQ_W-1:0];
		dot_sum = {dot_q[ACC_DOT_W-1], dot_q}
		        + {{(ACC_DOT_W + 1 - 18){prod_ab[17]}}, prod_ab};
		if (dot_sum[ACC_DOT_W] != dot_sum[ACC_DOT_W-1]) begin
			dot_next = dot_sum[ACC_DOT_W] ? {1'b1, {(ACC_DOT_W-1){1'b0}}}
			                              : {1'b0, {(ACC_DOT_W-1){1'b1}}};
		end else begin
			dot_next = dot_sum[ACC_DOT_W-1:0];
		end
	end

	// accumulators, cleared when the last beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_q  <= '0;
			sb_q  <= '0;
			dot_q <= '0;
		end else if (cmd.acc) begin
			if (in_data.last) begin
				sa_q  <= '0;
				sb_q  <= '0;
				dot_q <= '0;
			end else begin
				sa_q  <= sa_next;
				sb_q  <= sb_next;
				dot_q <= dot_next;
			end
		end
	end

	// search point and the test value k = 131073 - 2*mid, or 131073 on the first step
	always_comb begin
		mid     = lo_q + ((hi_q - lo_q + 18'd1) >> 1);
		k_val   = first_q ? $signed(K_TOP) : $signed(K_TOP - {mid, 1'b0});
		k_abs   = k_val[K_W-1] ? K_W'(-k_val) : k_val;
		dot_abs = dot_w_q[ACC_DOT_W-1] ? ACC_DOT_W'(-dot_w_q) : dot_w_q;
	end

	// multiplier operand select
	always_comb begin
		case (cmd.sel)
			MUL_P: begin
				mul_a = {{(MUL_A_W-ACC_SQ_W){1'b0}}, sa_w_q};
				mul_b = {{(MUL_B_W-ACC_SQ_W){1'b0}}, sb_w_q};
			end
			MUL_D: begin
				mul_a = {{(MUL_A_W-ACC_DOT_W){1'b0}}, dot_abs};
				mul_b = {{(MUL_B_W-ACC_DOT_W){1'b0}}, dot_abs};
			end
			MUL_K: begin
				mul_a = {{(MUL_A_W-DIST_W){1'b0}}, k_abs[DIST_W-1:0]};
				mul_b = {{(MUL_B_W-DIST_W){1'b0}}, k_abs[DIST_W-1:0]};
			end
			default: begin
				mul_a = p_q;
				mul_b = ksq_q;
			end
		endcase
	end

	cd_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	// exact test: 131072*dot <= k*sqrt(p), in squared form
	always_comb begin
		lhs = {dsq_q, {LHS_SHIFT{1'b0}}};
		if (dot_w_q == '0) begin
			test = !kneg_q;
		end else if (!dot_w_q[ACC_DOT_W-1]) begin
			test = !kneg_q && (lhs <= mul_prod);
		end else begin
			test = kneg_q ? (lhs >= mul_prod) : 1'b1;
		end
	end

	// working registers of the final computation
	always_ff @(posedge clk) begin
		if (cmd.acc && in_data.last) begin
			sa_w_q   <= sa_next;
			sb_w_q   <= sb_next;
			dot_w_q  <= dot_next;
			zero_w_q <= (sa_next == '0) || (sb_next == '0);
			lo_q     <= '0;
			hi_q     <= TWO_FIX;
			first_q  <= 1'b1;
		end
		if (cmd.store_p) begin
			p_q <= mul_prod[MUL_A_W-1:0];
		end
		if (cmd.store_d) begin
			dsq_q <= mul_prod[DSQ_W-1:0];
		end
		if (cmd.store_k) begin
			ksq_q <= mul_prod[KSQ_W-1:0];
		end
		if (cmd.mul_start && cmd.sel == MUL_K) begin
			kneg_q <= k_val[K_W-1];
		end
		if (cmd.decide) begin
			if (first_q) begin
				first_q <= 1'b0;
				if (!test) begin
					lo_q <= '0;
					hi_q <= '0;
				end
			end else if (test) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid - 18'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.distance  <= zero_w_q ? '0 : lo_q;
			out_q.zero_norm <= zero_w_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.mul_done    = mul_done;
	assign sts.zero_norm   = zero_w_q;
	assign sts.search_done = !first_q && (lo_q >= hi_q);
	assign sts.out_free    = !out_valid_q || !out_stall;

endmodule

// ----- hdl/cd_ctrl.sv -----
module cd_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_last,
	output logic         in_stall,
	input  cd_pkg::sts_t sts,
	output cd_pkg::cmd_t cmd
);
	import cd_pkg::*;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.sel       = MUL_P;
		in_stall      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.acc  = in_valid;
				if (in_valid && in_last) begin
					state_d = ST_P_GO;
				end
			end
			ST_P_GO: begin
				if (sts.zero_norm) begin
					state_d = ST_OUT;
				end else begin
					cmd.mul_start = 1'b1;
					state_d       = ST_P_WAIT;
				end
			end
			ST_P_WAIT: begin
				cmd.store_p = sts.mul_done;
				if (sts.mul_done) begin
					state_d = ST_D_GO;
				end
			end
			ST_D_GO: begin
				cmd.sel       = MUL_D;
				cmd.mul_start = 1'b1;
				state_d       = ST_D_WAIT;
			end
			ST_D_WAIT: begin
				cmd.sel     = MUL_D;
				cmd.store_d = sts.mul_done;
				if (sts.mul_done) begin
					state_d = ST_K_GO;
				end
			end
			ST_K_GO: begin
				cmd.sel       = MUL_K;
				cmd.mul_start = 1'b1;
				state_d       = ST_K_WAIT;
			end
			ST_K_WAIT: begin
				cmd.sel     = MUL_K;
				cmd.store_k = sts.mul_done;
				if (sts.mul_done) begin
					state_d = ST_R_GO;
				end
			end
			ST_R_GO: begin
				cmd.sel       = MUL_R;
				cmd.mul_start = 1'b1;
				state_d       = ST_R_WAIT;
			end
			ST_R_WAIT: begin
				cmd.sel = MUL_R;
				if (sts.mul_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.sel    = MUL_R;
				cmd.decide = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				// keep searching until the bracket closes
				if (!sts.zero_norm && !sts.search_done) begin
					state_d = ST_K_GO;
				end else if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/cosine_distance_8bit_vectors.sv -----
// Cosine distance of two byte vectors.
// Input channel: one beat carries one element pair (a_elem, b_elem) and last.
// Non-last beats are taken at one per cycle and go into three accumulators.
// The beat with last set closes the vectors; the block then stalls its input
// while it computes 1 - dot/sqrt(|a|^2 |b|^2) in 16-bit fraction fixed point.
// That computation uses one shift-add multiplier (one bit per cycle) for the
// norm product and dot square, then a binary search over the 18-bit result,
// each step a k^2 and a k^2*norm product; zero norms skip it.
// Output channel: one beat per vector, held in an output register; while the
// receiver stalls it, the block keeps accepting element beats of the next
// vector and only waits if that vector's result is ready before the first one
// is taken. Result: distance (0..2.0) and zero_norm, distance 0 when either
// norm is zero.
// Reset clears accumulators and control, and sets element_signed to 1.
// Config: APB register 0 (address 0), bit 0 = element_signed; write it only
// while the block is idle.
module cosine_distance_8bit_vectors (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cd_pkg::in_item_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output cd_pkg::out_item_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import cd_pkg::*;

	logic element_signed_q;
	cmd_t cmd;
	sts_t sts;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_signed_q <= 1'b1;
		end else if (psel && penable && pwrite && pready
		             && {1'b0, paddr[2]} == REG_ELEMENT_SIGNED) begin
			element_signed_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = ({1'b0, paddr[2]} == REG_ELEMENT_SIGNED)
	              ? {31'd0, element_signed_q} : 32'd0;

	cd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_data.last),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.element_signed (element_signed_q),
		.in_data        (in_data),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data)
	);

endmodule
